/* rtl/core/bfsa_pkg.sv */
// Package for the batched free-list slot allocator.
// Shared widths, codes and the command struct; no dependencies.
package bfsa_pkg;

	localparam int POOL_SLOTS = 1024;
	localparam int IDX_W = $clog2(POOL_SLOTS);
	localparam int CNT_W = $clog2(POOL_SLOTS + 1);
	localparam int LINK_W = IDX_W + 1;

	localparam int SLOT_W = 10;
	localparam int REG_W = 11;
	localparam int CFG_IDX_W = 2;

	localparam logic [REG_W-1:0] CNT_MAX = 11'd2047;

	// operation codes on mode
	localparam logic [1:0] MODE_ALLOC = 2'd0;
	localparam logic [1:0] MODE_FREE = 2'd1;
	localparam logic [1:0] MODE_ALLOC_AFTER_GC = 2'd2;

	// result codes on status
	localparam logic [1:0] ST_ALLOCATED = 2'd0;
	localparam logic [1:0] ST_GC_REQUEST = 2'd1;
	localparam logic [1:0] ST_OUT_OF_MEMORY = 2'd2;
	localparam logic [1:0] ST_FREED = 2'd3;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_BATCH_SLOTS = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_BATCHES_PER_COLLECT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_COLLECT_ENABLE = 2'd2;

	typedef struct packed {
		logic capture;  // take a new word, launch link read at free_head
		logic exec;     // link data is back, update state and result
	} bfsa_cmd_t;

	function automatic logic [REG_W-1:0] sat_inc(input logic [REG_W-1:0] v);
		sat_inc = (v < CNT_MAX) ? v + 1'b1 : CNT_MAX;
	endfunction

endpackage

/* rtl/core/batched_free_list_slot_allocator.sv */
// Top level of the batched free-list slot allocator.
// Depends on bfsa_pkg, bfsa_ctrl, bfsa_dp (and bfsa_ram below it).
//
// Usage:
//   Command channel: drive mode/slot with start; the word is taken at an edge
//   where start is high and busy is low. mode 0 allocs (with the collection
//   check), 1 frees slot, 2 or 3 allocs without the check.
//   Result channel: done is high for exactly one cycle with status,
//   granted_slot and high_water. The receiver cannot stall; the word must be
//   taken in that cycle.
//   Config channel: cfg_valid/cfg_ready with cfg_index/cfg_data; cfg_ready is
//   always high. Index 0 batch_slots, 1 batches_per_collect, 2 collect_enable,
//   index 3 is ignored. Write only while the block is idle.
// Timing:
//   Accept edge launches the link-memory read at the free-list head; the next
//   cycle updates state from the registered read data; done follows in the
//   cycle after that. busy is high in the update cycle, so no new word is
//   taken until state is updated, as a pop needs the synchronous link read.
//   The next command may be taken in the same cycle as the done strobe.
// Reset: arst_n clears list, counters and config to defaults at once; the link
//   memory is not cleared, only entries written by a free are ever used.
module batched_free_list_slot_allocator
	import bfsa_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	// command
	input  logic                 start,
	output logic                 busy,
	input  logic [1:0]           mode,
	input  logic [SLOT_W-1:0]    slot,
	// result
	output logic                 done,
	output logic [1:0]           status,
	output logic [SLOT_W-1:0]    granted_slot,
	output logic [REG_W-1:0]     high_water,
	// configuration
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [REG_W-1:0]     cfg_data
);

	bfsa_cmd_t cmd;

	// config registers are simple flops, always writable
	assign cfg_ready = 1'b1;

	bfsa_ctrl u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.busy  (busy),
		.done  (done),
		.cmd   (cmd)
	);

	bfsa_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.mode        (mode),
		.slot        (slot),
		.cfg_we      (cfg_valid && cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.status      (status),
		.granted_slot(granted_slot),
		.high_water  (high_water)
	);

endmodule

/* rtl/core/bfsa_ram.sv */
// Generic single-clock RAM, one write and one registered read port.
// No dependencies.
module bfsa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

/* rtl/core/bfsa_ctrl.sv */
// Controller for the slot allocator: accept/execute sequencing and done strobe.
// Depends on bfsa_pkg.
module bfsa_ctrl
	import bfsa_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	output logic      busy,
	output logic      done,
	output bfsa_cmd_t cmd
);

	localparam logic S_IDLE = 1'b0;
	localparam logic S_EXEC = 1'b1;

	logic state_q;
	logic done_q;

	assign busy = (state_q != S_IDLE);
	assign cmd.capture = start && !busy;
	assign cmd.exec = (state_q == S_EXEC);
	assign done = done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done_q <= 1'b0;
		end else begin
			done_q <= cmd.exec;
			unique case (state_q)
				S_IDLE: begin
					if (cmd.capture) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

/* rtl/core/bfsa_dp.sv */
// Datapath for the slot allocator: config registers, free list, batch counters,
// link memory and result registers. Depends on bfsa_pkg and bfsa_ram.
module bfsa_dp
	import bfsa_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  bfsa_cmd_t            cmd,
	input  logic [1:0]           mode,
	input  logic [SLOT_W-1:0]    slot,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [REG_W-1:0]     cfg_data,
	output logic [1:0]           status,
	output logic [SLOT_W-1:0]    granted_slot,
	output logic [REG_W-1:0]     high_water
);

	// configuration
	logic [REG_W-1:0] batch_slots_q;
	logic [REG_W-1:0] batches_per_collect_q;
	logic             collect_enable_q;

	// allocator state
	logic [IDX_W-1:0] free_head_q;
	logic             free_empty_q;
	logic [REG_W-1:0] batch_count_q;
	logic [REG_W-1:0] fill_in_batch_q;
	logic [REG_W-1:0] batches_since_collect_q;
	logic [CNT_W-1:0] fresh_count_q;

	// captured word
	logic [1:0]        mode_q;
	logic [SLOT_W-1:0] slot_q;

	// link memory: {end mark, next handle}
	logic [LINK_W-1:0] link_rd;
	logic              link_we;
	logic [IDX_W-1:0]  link_waddr;

	logic [REG_W-1:0] bs_eff;
	logic [REG_W-1:0] bpc_eff;
	logic             is_free;
	logic             checked;
	logic             slot_ok;
	logic             batch_full;
	logic             want_gc;
	logic             no_room;
	logic [CNT_W-1:0] fresh_next;

	assign bs_eff = (batch_slots_q == '0) ? REG_W'(1) : batch_slots_q;
	assign bpc_eff = (batches_per_collect_q == '0) ? REG_W'(1) : batches_per_collect_q;
	assign is_free = (mode_q == MODE_FREE);
	assign checked = (mode_q == MODE_ALLOC);
	assign slot_ok = (32'(slot_q) < 32'(POOL_SLOTS));
	assign batch_full = (batch_count_q == '0) || (fill_in_batch_q >= bs_eff);
	assign want_gc = checked && collect_enable_q && batch_full
		&& (batches_since_collect_q >= bpc_eff);
	assign no_room = (32'(fresh_count_q) >= 32'(POOL_SLOTS));

	assign link_we = cmd.exec && is_free && slot_ok;
	assign link_waddr = IDX_W'(slot_q);

	bfsa_ram #(
		.WIDTH(LINK_W),
		.DEPTH(POOL_SLOTS)
	) u_link_ram (
		.clk  (clk),
		.we   (link_we),
		.waddr(link_waddr),
		.wdata({free_empty_q, free_head_q}),
		.re   (cmd.capture),
		.raddr(free_head_q),
		.rdata(link_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			batch_slots_q <= 11'd16;
			batches_per_collect_q <= 11'd4;
			collect_enable_q <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_BATCH_SLOTS: batch_slots_q <= cfg_data;
				CFG_BATCHES_PER_COLLECT: batches_per_collect_q <= cfg_data;
				CFG_COLLECT_ENABLE: collect_enable_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			mode_q <= mode;
			slot_q <= slot;
		end
	end

	always_comb begin
		fresh_next = fresh_count_q;
		if (!is_free && free_empty_q && !want_gc && !no_room) begin
			fresh_next = fresh_count_q + 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			free_head_q <= '0;
			free_empty_q <= 1'b1;
			batch_count_q <= '0;
			fill_in_batch_q <= '0;
			batches_since_collect_q <= '0;
			fresh_count_q <= '0;
		end else if (cmd.exec) begin
			priority if (is_free) begin
				if (slot_ok) begin
					free_head_q <= IDX_W'(slot_q);
					free_empty_q <= 1'b0;
				end
			end else if (!free_empty_q) begin
				// pop: link data for the head came back this cycle
				free_head_q <= link_rd[IDX_W-1:0];
				free_empty_q <= link_rd[IDX_W];
			end else if (want_gc) begin
				batches_since_collect_q <= '0;
			end else if (!no_room) begin
				if (batch_full) begin
					batch_count_q <= sat_inc(batch_count_q);
					batches_since_collect_q <= sat_inc(batches_since_collect_q);
					fill_in_batch_q <= REG_W'(1);
				end else begin
					fill_in_batch_q <= sat_inc(fill_in_batch_q);
				end
				fresh_count_q <= fresh_next;
			end
		end
	end

	// result registers, valid in the cycle after exec
	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			priority if (is_free) begin
				status <= ST_FREED;
				granted_slot <= '0;
			end else if (!free_empty_q) begin
				status <= ST_ALLOCATED;
				granted_slot <= SLOT_W'(free_head_q);
			end else if (want_gc) begin
				status <= ST_GC_REQUEST;
				granted_slot <= '0;
			end else if (no_room) begin
				status <= ST_OUT_OF_MEMORY;
				granted_slot <= '0;
			end else begin
				status <= ST_ALLOCATED;
				granted_slot <= SLOT_W'(fresh_count_q);
			end
			high_water <= (32'(fresh_next) < 32'(CNT_MAX)) ? REG_W'(fresh_next) : CNT_MAX;
		end
	end

endmodule

/* bench/tb_top.sv */
// Self-checking bench for batched_free_list_slot_allocator.
// Depends on bfsa_pkg and the allocator RTL; a pool model predicts each untyped word.
`timescale 1ns / 1ps

module tb_top
	import bfsa_pkg::*;
();

	// mode 3 decodes like alloc_after_gc; register index 3 is a hole
	localparam logic [1:0]           MODE_SPARE = 2'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE  = 2'd3;

	typedef struct packed {
		logic [1:0]        status;
		logic [SLOT_W-1:0] slot;
		logic [REG_W-1:0]  hw;
	} grant_word_t;

	typedef enum bit {ROW_WORD, ROW_CFG} row_kind_t;

	typedef struct {
		row_kind_t         kind;
		logic [1:0]        mode;
		logic [SLOT_W-1:0] slot;
		bit                typed;   // expected word typed in by hand
		grant_word_t       want;
		logic [REG_W-1:0]  bs;
		logic [REG_W-1:0]  bpc;
		logic              ce;
		bit                poke;    // also hit the unused register index
	} dir_row_t;

	logic                 clk;
	logic                 arst_n;
	logic                 start;
	logic                 busy;
	logic [1:0]           mode;
	logic [SLOT_W-1:0]    slot;
	logic                 done;
	logic [1:0]           status;
	logic [SLOT_W-1:0]    granted_slot;
	logic [REG_W-1:0]     high_water;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [REG_W-1:0]     cfg_data;

	batched_free_list_slot_allocator u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.mode         (mode),
		.slot         (slot),
		.done         (done),
		.status       (status),
		.granted_slot (granted_slot),
		.high_water   (high_water),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	// ---------------------------------------------------------------
	// Pool model: free list, batch bookkeeping and config shadow
	// ---------------------------------------------------------------
	logic [SLOT_W-1:0] link_mem [0:POOL_SLOTS-1];
	bit                end_mark [0:POOL_SLOTS-1];
	logic [SLOT_W-1:0] list_head;
	bit                list_empty;
	logic [REG_W-1:0]  batch_cnt;
	logic [REG_W-1:0]  batch_fill;
	logic [REG_W-1:0]  since_gc;
	logic [REG_W-1:0]  fresh_cnt;
	logic [REG_W-1:0]  cfg_batch;
	logic [REG_W-1:0]  cfg_period;
	logic              cfg_collect;

	grant_word_t       grant_q[$];   // predicted words, oldest first
	logic [SLOT_W-1:0] held_q[$];    // slots the host currently owns
	dir_row_t          dir_tab[$];
	int unsigned       errors;

	function automatic logic [REG_W-1:0] bump_sat(input logic [REG_W-1:0] v);
		bump_sat = (v == {REG_W{1'b1}}) ? v : v + 1'b1;
	endfunction

	// One word through the pool: push on free, pop if the list holds
	// anything, else bump through the batch (or ask for a collection, or report out of memory).
	task automatic pool_step(input logic [1:0] md, input logic [SLOT_W-1:0] sl,
			output grant_word_t w);
		logic [REG_W-1:0] bs;
		logic [REG_W-1:0] bpc;
		bit               full;
		bs  = (cfg_batch == '0) ? REG_W'(1) : cfg_batch;   // zero batch acts as one
		bpc = (cfg_period == '0) ? REG_W'(1) : cfg_period; // zero period acts as one
		w = '0;
		if (md == MODE_FREE) begin
			link_mem[sl] = list_head;
			end_mark[sl] = list_empty;
			list_head    = sl;
			list_empty   = 0;
			w.status     = ST_FREED;
		end else if (!list_empty) begin
			w.slot     = list_head;
			list_empty = end_mark[list_head];
			list_head  = link_mem[list_head];
			w.status   = ST_ALLOCATED;
		end else begin
			full = (batch_cnt == '0) || (batch_fill >= bs);
			// only plain alloc runs the collection check; bit 1 of mode skips it
			if (md == MODE_ALLOC && cfg_collect && full && since_gc >= bpc) begin
				since_gc = '0;
				w.status = ST_GC_REQUEST;
			end else if (fresh_cnt >= POOL_SLOTS) begin
				w.status = ST_OUT_OF_MEMORY;
			end else begin
				if (full) begin
					batch_cnt  = bump_sat(batch_cnt);
					since_gc   = bump_sat(since_gc);
					batch_fill = '0;
				end
				w.slot     = fresh_cnt[SLOT_W-1:0];
				fresh_cnt  = fresh_cnt + 1'b1;
				batch_fill = bump_sat(batch_fill);
				w.status   = ST_ALLOCATED;
			end
		end
		w.hw = fresh_cnt;
	endtask

	// ---------------------------------------------------------------
	// Drivers; every task is entered and left at a falling edge
	// ---------------------------------------------------------------
	task automatic send_word(input logic [1:0] md, input logic [SLOT_W-1:0] sl,
			input bit typed, input grant_word_t typed_w, output grant_word_t w);
		start <= 1'b1;
		mode  <= md;
		slot  <= sl;
		@(posedge clk);
		while (busy) @(posedge clk);
		// accepted at this edge: predict and queue the word
		pool_step(md, sl, w);
		if (typed)
			w = typed_w;
		grant_q.push_back(w);
		if (w.status == ST_ALLOCATED)
			held_q.push_back(w.slot);
		@(negedge clk);
	endtask

	task automatic idle_cycles(input int n);
		start <= 1'b0;
		repeat (n) @(negedge clk);
	endtask

	// sender holds off until every predicted word has come back
	task automatic wait_quiet();
		start <= 1'b0;
		while (grant_q.size() != 0) @(negedge clk);
		repeat (3) @(negedge clk);   // slack after the last word
	endtask

	task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [REG_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		case (idx)
			CFG_BATCH_SLOTS:         cfg_batch   = data;
			CFG_BATCHES_PER_COLLECT: cfg_period  = data;
			CFG_COLLECT_ENABLE:      cfg_collect = data[0];
			default: ;               // unused index is dropped
		endcase
		@(negedge clk);
	endtask

	// registers only change with the block idle
	task automatic set_policy(input logic [REG_W-1:0] bs, input logic [REG_W-1:0] bpc,
			input logic ce, input bit poke);
		wait_quiet();
		if (poke)
			cfg_write(CFG_SPARE, REG_W'($urandom_range(0, 2047)));
		cfg_write(CFG_BATCH_SLOTS, bs);
		cfg_write(CFG_BATCHES_PER_COLLECT, bpc);
		cfg_write(CFG_COLLECT_ENABLE, {{(REG_W-1){1'b0}}, ce});
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [REG_W-1:0] pick_reg();
		case ($urandom_range(0, 9))
			0:       pick_reg = '0;
			1:       pick_reg = 11'd1;
			2:       pick_reg = 11'd2047;
			3:       pick_reg = 11'd1024;
			4:       pick_reg = REG_W'($urandom_range(0, 2047));
			default: pick_reg = REG_W'($urandom_range(1, 8));
		endcase
	endfunction

	// One host action. Mostly allocs and frees of owned slots; a gc
	// request is usually answered by a few frees and an alloc_after_gc.
	task automatic host_step(input int alloc_pct);
		int          r;
		int          i;
		int          n;
		logic [1:0]  md;
		logic [SLOT_W-1:0] sl;
		grant_word_t w;
		r = $urandom_range(0, 99);
		if (r < alloc_pct) begin
			i  = $urandom_range(0, 19);
			md = (i < 14) ? MODE_ALLOC : (i < 19) ? MODE_ALLOC_AFTER_GC : MODE_SPARE;
			sl = SLOT_W'($urandom_range(0, POOL_SLOTS - 1));
		end else if (r < 96 && held_q.size() != 0) begin
			i  = $urandom_range(0, held_q.size() - 1);
			sl = held_q[i];
			held_q.delete(i);
			md = MODE_FREE;
		end else begin
			// stray free: double free or never-granted slot
			md = MODE_FREE;
			sl = SLOT_W'($urandom_range(0, POOL_SLOTS - 1));
		end
		send_word(md, sl, 0, '0, w);
		if (w.status == ST_GC_REQUEST && $urandom_range(0, 9) < 8) begin
			n = $urandom_range(1, 4);
			repeat (n) begin
				if (held_q.size() != 0) begin
					i  = $urandom_range(0, held_q.size() - 1);
					sl = held_q[i];
					held_q.delete(i);
					send_word(MODE_FREE, sl, 0, '0, w);
				end
			end
			send_word(MODE_ALLOC_AFTER_GC, SLOT_W'($urandom_range(0, POOL_SLOTS - 1)),
				0, '0, w);
		end
	endtask

	function automatic grant_word_t gw(input logic [1:0] st, input logic [SLOT_W-1:0] gs,
			input logic [REG_W-1:0] hw);
		gw.status = st;
		gw.slot   = gs;
		gw.hw     = hw;
	endfunction

	task automatic add_word(input logic [1:0] md, input logic [SLOT_W-1:0] sl,
			input bit typed, input grant_word_t want);
		dir_row_t row;
		row.kind  = ROW_WORD;
		row.mode  = md;
		row.slot  = sl;
		row.typed = typed;
		row.want  = want;
		row.bs    = '0;
		row.bpc   = '0;
		row.ce    = 1'b0;
		row.poke  = 0;
		dir_tab.push_back(row);
	endtask

	task automatic add_cfg(input logic [REG_W-1:0] bs, input logic [REG_W-1:0] bpc,
			input logic ce, input bit poke);
		dir_row_t row;
		row.kind  = ROW_CFG;
		row.mode  = MODE_ALLOC;
		row.slot  = '0;
		row.typed = 0;
		row.want  = '0;
		row.bs    = bs;
		row.bpc   = bpc;
		row.ce    = ce;
		row.poke  = poke;
		dir_tab.push_back(row);
	endtask

	// ---------------------------------------------------------------
	// Clock and watchdog
	// ---------------------------------------------------------------
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// far beyond the slowest legal run
	initial begin
		#2_000_000;
		$display("batched_free_list_slot_allocator test failed");
		$finish;
	end

	// ---------------------------------------------------------------
	// Result checker: done marks a word for one cycle, no back-pressure
	// ---------------------------------------------------------------
	always @(posedge clk) begin
		grant_word_t w;
		if (arst_n === 1'b1 && done === 1'b1) begin
			if (grant_q.size() == 0) begin
				$display("%0t: unexpected word status %0d slot %0d high_water %0d",
					$time, status, granted_slot, high_water);
				errors++;
			end else begin
				w = grant_q.pop_front();
				if (status !== w.status) begin
					$display("%0t: status expected %0d actual %0d", $time, w.status, status);
					errors++;
				end
				if (granted_slot !== w.slot) begin
					$display("%0t: granted_slot expected %0d actual %0d",
						$time, w.slot, granted_slot);
					errors++;
				end
				if (high_water !== w.hw) begin
					$display("%0t: high_water expected %0d actual %0d",
						$time, w.hw, high_water);
					errors++;
				end
			end
		end
	end

	// ---------------------------------------------------------------
	// Stimulus
	// ---------------------------------------------------------------
	initial begin
		grant_word_t w;
		int          idle_pct;
		int          alloc_pct;
		int          waited;
		errors    = 0;
		arst_n    = 1'b0;
		start     = 1'b0;
		mode      = MODE_ALLOC;
		slot      = '0;
		cfg_valid = 1'b0;
		cfg_index = CFG_BATCH_SLOTS;
		cfg_data  = '0;
		// reset state of the model, register defaults included
		list_head   = '0;
		list_empty  = 1;
		batch_cnt   = '0;
		batch_fill  = '0;
		since_gc    = '0;
		fresh_cnt   = '0;
		cfg_batch   = 11'd16;
		cfg_period  = 11'd4;
		cfg_collect = 1'b0;

		repeat (10) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed table. After reset: batch of 16, collection off.
		add_word(MODE_ALLOC,          10'd0,    1, gw(ST_ALLOCATED, 10'd0, 11'd1));
		add_word(MODE_ALLOC_AFTER_GC, 10'd0,    1, gw(ST_ALLOCATED, 10'd1, 11'd2));
		add_word(MODE_SPARE,          10'd0,    1, gw(ST_ALLOCATED, 10'd2, 11'd3));
		add_word(MODE_FREE,           10'd1,    0, '0);
		add_word(MODE_FREE,           10'd0,    0, '0);
		add_word(MODE_ALLOC,          10'd0,    0, '0);  // LIFO pop of 0
		add_word(MODE_ALLOC,          10'd0,    0, '0);  // pop of 1 empties list
		add_word(MODE_ALLOC,          10'd0,    0, '0);  // back to fresh slots
		add_word(MODE_FREE,           10'd1023, 0, '0);
		add_word(MODE_ALLOC,          10'd1023, 0, '0);
		add_word(MODE_ALLOC,          10'd1023, 0, '0);
		// zero batch size and zero period act as one; collection on
		add_cfg(11'd0, 11'd0, 1'b1, 0);
		add_word(MODE_ALLOC,          10'd0,    1, gw(ST_GC_REQUEST, 10'd0, 11'd5));
		add_word(MODE_ALLOC,          10'd0,    0, '0);
		add_word(MODE_ALLOC,          10'd0,    1, gw(ST_GC_REQUEST, 10'd0, 11'd6));
		add_word(MODE_ALLOC_AFTER_GC, 10'd0,    0, '0);
		add_word(MODE_ALLOC,          10'd0,    0, '0);
		add_word(MODE_SPARE,          10'd0,    0, '0);
		add_word(MODE_FREE,           10'd7,    0, '0);
		add_word(MODE_ALLOC,          10'd0,    0, '0);  // list wins over gc check
		add_cfg(11'd2047, 11'd2047, 1'b1, 1);
		add_word(MODE_ALLOC,          10'd0,    0, '0);
		add_cfg(11'd1024, 11'd1024, 1'b0, 0);
		add_word(MODE_ALLOC,          10'd0,    0, '0);

		foreach (dir_tab[i]) begin
			if (dir_tab[i].kind == ROW_CFG)
				set_policy(dir_tab[i].bs, dir_tab[i].bpc, dir_tab[i].ce, dir_tab[i].poke);
			else
				send_word(dir_tab[i].mode, dir_tab[i].slot, dir_tab[i].typed,
					dir_tab[i].want, w);
		end
		held_q.delete();

		// Random phases, each under its own policy. Odd phases run
		// back-to-back, even ones with idle bursts.
		for (int ph = 0; ph < 5; ph++) begin
			set_policy(pick_reg(), pick_reg(), ($urandom_range(0, 9) < 7), 0);
			idle_pct  = (ph % 2 == 0) ? $urandom_range(10, 40) : 0;
			alloc_pct = $urandom_range(62, 75);
			repeat (20) begin
				if ($urandom_range(0, 99) < idle_pct)
					idle_cycles($urandom_range(1, 4));
				host_step(alloc_pct);
			end
		end

		// Final stretch, no idling: use up every fresh slot, then keep
		// going so allocs on an empty list hit out_of_memory. Batches are
		// large here so gc requests stay rare.
		set_policy(REG_W'($urandom_range(32, 64)), REG_W'($urandom_range(1, 4)), 1'b1, 0);
		while (fresh_cnt < POOL_SLOTS)
			host_step(98);
		repeat (30)
			host_step(70);

		start  <= 1'b0;
		waited = 0;
		while (grant_q.size() != 0 && waited < 200) begin
			@(posedge clk);
			waited++;
		end
		if (grant_q.size() != 0) begin
			$display("%0t: %0d words never came back, next status expected %0d",
				$time, grant_q.size(), grant_q[0].status);
			errors++;
		end
		repeat (8) @(posedge clk);

		if (errors == 0)
			$display("batched_free_list_slot_allocator test passed");
		else
			$display("batched_free_list_slot_allocator test failed");
		$finish;
	end

endmodule

/* batched_free_list_slot_allocator.f */
rtl/core/bfsa_pkg.sv
rtl/core/bfsa_ram.sv
rtl/core/bfsa_ctrl.sv
rtl/core/bfsa_dp.sv
rtl/core/batched_free_list_slot_allocator.sv
bench/tb_top.sv
